// ===== design/ring_history_log_search_unit_defines.svh =====
// Assertion macros shared by the ring history log search checker.
// Expects signals named clock and reset in the scope of use.
`ifndef RING_HISTORY_LOG_SEARCH_UNIT_DEFINES_SVH
`define RING_HISTORY_LOG_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define RHLS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RHLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rhls_pkg.sv =====
// Package for the ring history log search unit: request codes, field widths
// and default sizes. No dependencies.
package rhls_pkg;

   localparam int unsigned DEPTH_DEF = 16;

   localparam int REQ_W       = 2;
   localparam int ID_W        = 16;
   localparam int TURN_W      = 32;
   localparam int CNT_W       = 4;
   localparam int REQ_TDATA_W = ID_W + TURN_W;           // 48, whole bytes
   localparam int RSP_FIELD_W = 1 + CNT_W + ID_W;        // 21
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [ID_W-1:0]  NULL_ID   = 16'd0;
   localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;

   localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
   localparam logic [REQ_W-1:0] REQ_MARK   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

   // rsp word bit positions
   localparam int RSP_SEEN_LSB = 0;
   localparam int RSP_CNT_LSB  = 1;
   localparam int RSP_EFF_LSB  = 1 + CNT_W;

endpackage

// ===== design/ring_history_log_search_unit.sv =====
// Ring history log search unit: circular event log in two synchronous memories
// with a backward search walk. Depends on rhls_pkg.
//
// Append, mark and unused codes give their result in the cycle after accept.
// A query walks back from the newest entry, one memory read per cycle, up to
// DEPTH-1 reads; its result follows the end of the walk, sooner if the walk hits
// an empty entry. One item at a time: no word is taken while a query walks. Reset
// is synchronous: pointer, control and per-entry valid bits clear; memory
// contents are not swept, an entry without its valid bit reads empty.
module ring_history_log_search_unit #(
   parameter int unsigned DEPTH = rhls_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] event_id, [47:16] turn_number
   input  logic [rhls_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] req_type
   input  logic [rhls_pkg::REQ_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] was_seen, [4:1] seen_count, [20:5] effective_id, [23:21] zero
   output logic [rhls_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import rhls_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] p);
      prev_slot = (p == '0) ? LAST_SLOT : p - AW'(1);
   endfunction

   logic [0:0]              state_ff, state_in;
   logic [AW-1:0]           wp_ff, wp_in;
   logic [AW-1:0]           ptr_ff, ptr_in;
   logic [AW-1:0]           left_ff, left_in;
   logic                    pend_ff;
   logic [ID_W-1:0]         qid_ff, qid_in;
   logic [TURN_W-1:0]       qturn_ff, qturn_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    have_ff, have_in;
   logic [ID_W-1:0]         effid_ff, effid_in;
   logic [DEPTH-1:0]        valid_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // entry store {turn, event} and effective flags
   logic [TURN_W+ID_W-1:0]  ent_mem [DEPTH];
   logic                    eff_mem [DEPTH];
   logic [TURN_W+ID_W-1:0]  rd_ent_ff;
   logic                    rd_eff_ff;
   logic                    rd_vld_ff;

   logic [REQ_W-1:0]        req_kind;
   logic [ID_W-1:0]         req_id;
   logic [TURN_W-1:0]       req_turn;
   logic                    req_accept;
   logic                    wr_ent_en, wr_eff_en, wr_eff_val;
   logic [AW-1:0]           wr_eff_addr;
   logic [ID_W-1:0]         rd_event;
   logic                    rd_eff;
   logic                    hit_null, rd_en, finish, turn_hit;

   assign req_kind = req_tuser;
   assign req_id   = req_tdata[ID_W-1:0];
   assign req_turn = req_tdata[REQ_TDATA_W-1:ID_W];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign wr_ent_en   = req_accept && (req_kind == REQ_APPEND);
   assign wr_eff_en   = req_accept && ((req_kind == REQ_APPEND) || (req_kind == REQ_MARK));
   assign wr_eff_addr = (req_kind == REQ_APPEND) ? wp_ff : prev_slot(wp_ff);
   assign wr_eff_val  = (req_kind == REQ_MARK);

   // never-written entries read as empty
   assign rd_event = rd_vld_ff ? rd_ent_ff[ID_W-1:0] : NULL_ID;
   assign rd_eff   = rd_vld_ff && rd_eff_ff;
   assign turn_hit = (rd_ent_ff[TURN_W+ID_W-1:ID_W] == qturn_ff);

   assign hit_null = pend_ff && (rd_event == NULL_ID);
   assign rd_en    = (state_ff == ST_WALK) && (left_ff != '0) && !hit_null;
   assign finish   = (state_ff == ST_WALK) && (hit_null || (!pend_ff && left_ff == '0));

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      qid_in       = qid_ff;
      qturn_in     = qturn_ff;
      cnt_in       = cnt_ff;
      have_in      = have_ff;
      effid_in     = effid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == REQ_QUERY) begin
                  state_in = ST_WALK;
                  ptr_in   = prev_slot(wp_ff);
                  left_in  = LAST_SLOT;
                  qid_in   = req_id;
                  qturn_in = req_turn;
                  cnt_in   = '0;
                  have_in  = 1'b0;
                  effid_in = NULL_ID;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  if (req_kind == REQ_APPEND) begin
                     wp_in = (wp_ff == LAST_SLOT) ? '0 : wp_ff + AW'(1);
                  end
               end
            end
         end
         ST_WALK: begin
            if (rd_en) begin
               ptr_in  = prev_slot(ptr_ff);
               left_in = left_ff - AW'(1);
            end
            if (pend_ff && !hit_null && turn_hit) begin
               if ((rd_event == qid_ff) && (cnt_ff != COUNT_MAX)) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (!have_ff && rd_eff) begin
                  have_in  = 1'b1;
                  effid_in = rd_event;
               end
            end
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[RSP_SEEN_LSB]                 = (cnt_ff != '0);
               rsp_data_in[RSP_CNT_LSB +: CNT_W]         = cnt_ff;
               rsp_data_in[RSP_EFF_LSB +: ID_W]          = effid_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         pend_ff      <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_ent_en) begin
            valid_ff[wp_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      left_ff     <= left_in;
      qid_ff      <= qid_in;
      qturn_ff    <= qturn_in;
      cnt_ff      <= cnt_in;
      have_ff     <= have_in;
      effid_ff    <= effid_in;
      rsp_data_ff <= rsp_data_in;
   end

   // memory ports: writes only while idle, reads only during the walk
   always_ff @(posedge clock) begin
      if (wr_ent_en) begin
         ent_mem[wp_ff] <= {req_turn, req_id};
      end
      if (wr_eff_en) begin
         eff_mem[wr_eff_addr] <= wr_eff_val;
      end
      if (rd_en) begin
         rd_ent_ff <= ent_mem[ptr_ff];
         rd_eff_ff <= eff_mem[ptr_ff];
         rd_vld_ff <= valid_ff[ptr_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/rhls_checker.sv =====
// Port-level checker for the ring history log search unit, bound to the top.
// Depends on rhls_pkg and ring_history_log_search_unit_defines.svh.
`include "ring_history_log_search_unit_defines.svh"

module rhls_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [rhls_pkg::REQ_W-1:0]        req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rhls_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import rhls_pkg::*;

   logic req_fire, rsp_stall, rsp_seen_ok;

   assign req_fire    = req_tvalid && req_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_seen_ok = rsp_tdata[RSP_SEEN_LSB] == (rsp_tdata[RSP_CNT_LSB +: CNT_W] != '0);

   `RHLS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")
   `RHLS_ASSERT_NOW(a_no_take_on_stall, rsp_stall, !req_fire, "req word taken while rsp stalled")
   `RHLS_ASSERT_NEXT(a_append_zero, req_fire && (req_tuser == REQ_APPEND), rsp_tvalid && (rsp_tdata == '0), "append result not an immediate zero word")
   `RHLS_ASSERT_NOW(a_seen_count, rsp_tvalid, rsp_seen_ok, "was_seen disagrees with seen_count")

endmodule

bind ring_history_log_search_unit rhls_checker u_rhls_checker (.*);

// ===== sim/ring_history_log_search_unit_tb.sv =====
// Self-checking testbench for ring_history_log_search_unit: random and directed
// append/mark/query and unused-code words, with an in-bench model of the event ring.
// Depends on rhls_pkg and the unit's RTL.
`timescale 1ns / 100ps

module ring_history_log_search_unit_tb;
   import rhls_pkg::*;

   localparam int DEPTH = DEPTH_DEF;
   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_AT = 250;       // accepted words before the long receiver stall
   localparam int HOLD_CYCLES = 200;
   localparam int STEADY_LO = 450;     // window of accepted words with no idling
   localparam int STEADY_HI = 600;

   typedef struct packed {
      logic [REQ_W-1:0]  kind;
      logic [ID_W-1:0]   id;
      logic [TURN_W-1:0] turn;
   } log_req_type;

   typedef struct packed {
      logic             seen;
      logic [CNT_W-1:0] cnt;
      logic [ID_W-1:0]  eff;
   } log_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   ring_history_log_search_unit #(.DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   // model of the ring
   logic [ID_W-1:0]   ring_event [DEPTH];
   logic [TURN_W-1:0] ring_turn  [DEPTH];
   logic              ring_eff   [DEPTH];
   logic [PTR_W-1:0]  ring_wp;

   log_req_type req_backlog[$];
   log_rsp_type awaited_lookups[$];
   log_req_type offered;
   int n_items = 0;
   int acc_count = 0;
   int rsp_count = 0;
   int n_append = 0, n_mark = 0, n_query = 0, n_hits = 0, n_eff = 0, n_unused = 0;
   int errors = 0;
   int cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   logic [ID_W-1:0]   id_pool [4];
   logic [TURN_W-1:0] turn_pool [3];
   log_req_type recent_keys[$];

   function automatic log_rsp_type ring_apply(log_req_type r);
      log_rsp_type res;
      logic [PTR_W-1:0] p;
      logic have_eff;
      res = '0;
      have_eff = 1'b0;
      case (r.kind)
         REQ_APPEND: begin
            ring_event[ring_wp] = r.id;
            ring_turn[ring_wp] = r.turn;
            ring_eff[ring_wp] = 1'b0;
            ring_wp = (ring_wp == PTR_W'(DEPTH - 1)) ? '0 : ring_wp + 1'b1;
         end
         REQ_MARK: begin
            ring_eff[(ring_wp == '0) ? PTR_W'(DEPTH - 1) : ring_wp - 1'b1] = 1'b1;
         end
         REQ_QUERY: begin
            p = ring_wp;
            // walk back; the slot at the write pointer is never examined
            for (int i = 0; i < DEPTH; i++) begin
               p = (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
               if (p == ring_wp || ring_event[p] == NULL_ID) break;
               if (ring_turn[p] == r.turn) begin
                  if (ring_event[p] == r.id && res.cnt < COUNT_MAX) res.cnt++;
                  if (!have_eff && ring_eff[p]) begin
                     have_eff = 1'b1;
                     res.eff = ring_event[p];
                  end
               end
            end
            res.seen = (res.cnt != '0);
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic queue_req(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
                            logic [TURN_W-1:0] turn);
      log_req_type r;
      r.kind = kind;
      r.id = id;
      r.turn = turn;
      req_backlog.push_back(r);
      if (kind != REQ_UNUSED) n_items++;
      if (kind == REQ_APPEND) begin
         recent_keys.push_back(r);
         if (recent_keys.size() > DEPTH) void'(recent_keys.pop_front());
      end
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, 3)];
      return ID_W'($urandom);
   endfunction

   function automatic logic [TURN_W-1:0] pick_turn();
      if ($urandom_range(0, 99) < 85) return turn_pool[$urandom_range(0, 2)];
      return $urandom;
   endfunction

   task automatic queue_query();
      log_req_type k;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70 && recent_keys.size() != 0) begin
         k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
         queue_req(REQ_QUERY, k.id, k.turn);
      end else if (sel < 80) begin
         queue_req(REQ_QUERY, NULL_ID, pick_turn());
      end else begin
         queue_req(REQ_QUERY, pick_id(), pick_turn());
      end
   endtask

   // driver: offers backlog words, updates the model on each accepted word
   always @(posedge clock) begin
      bit steady;
      steady = (acc_count >= STEADY_LO && acc_count < STEADY_HI);
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            log_rsp_type r;
            r = ring_apply(offered);
            awaited_lookups.push_back(r);
            acc_count++;
            case (offered.kind)
               REQ_APPEND: n_append++;
               REQ_MARK:   n_mark++;
               REQ_QUERY: begin
                  n_query++;
                  if (r.seen) n_hits++;
                  if (r.eff != NULL_ID) n_eff++;
               end
               default:    n_unused++;
            endcase
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
               offered = req_backlog.pop_front();
               req_tdata <= {offered.turn, offered.id};
               req_tuser <= offered.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks result words in order, drives rsp_tready
   always @(posedge clock) begin
      log_rsp_type want;
      bit steady;
      steady = (acc_count >= STEADY_LO && acc_count < STEADY_HI);
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (awaited_lookups.size() == 0) begin
               $error("result word 0x%h with none awaited", rsp_tdata);
               errors++;
            end else begin
               want = awaited_lookups.pop_front();
               if (rsp_tdata[RSP_SEEN_LSB] !== want.seen) begin
                  $error("was_seen: expected %0d, got %0d", want.seen, rsp_tdata[RSP_SEEN_LSB]);
                  errors++;
               end
               if (rsp_tdata[RSP_CNT_LSB +: CNT_W] !== want.cnt) begin
                  $error("seen_count: expected %0d, got %0d", want.cnt,
                         rsp_tdata[RSP_CNT_LSB +: CNT_W]);
                  errors++;
               end
               if (rsp_tdata[RSP_EFF_LSB +: ID_W] !== want.eff) begin
                  $error("effective_id: expected 0x%h, got 0x%h", want.eff,
                         rsp_tdata[RSP_EFF_LSB +: ID_W]);
                  errors++;
               end
               if (rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W] !== '0) begin
                  $error("pad bits: expected 0, got 0x%h",
                         rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W]);
                  errors++;
               end
            end
         end
         // one long stall so the unit backs up while words keep coming
         if (!hold_done && acc_count >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 25);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int kind_sel;
      int n;
      log_req_type k;
      for (int i = 0; i < DEPTH; i++) begin
         ring_event[i] = NULL_ID;
         ring_turn[i] = '0;
         ring_eff[i] = 1'b0;
      end
      ring_wp = '0;

      // directed: empty ring, mark with nothing logged, unused code, extremes
      queue_req(REQ_QUERY, 16'd5, 32'd7);
      queue_req(REQ_MARK, '0, '0);
      queue_req(REQ_UNUSED, '1, '1);
      queue_req(REQ_APPEND, 16'hFFFF, 32'hFFFF_FFFF);
      queue_req(REQ_MARK, '1, '1);
      queue_req(REQ_APPEND, 16'h0001, 32'd0);
      queue_req(REQ_QUERY, 16'hFFFF, 32'hFFFF_FFFF);
      queue_req(REQ_QUERY, NULL_ID, 32'd0);
      // null id stored: later walks end there
      queue_req(REQ_APPEND, NULL_ID, 32'hFFFF_FFFF);
      queue_req(REQ_QUERY, 16'hFFFF, 32'hFFFF_FFFF);
      // full ring of one key: wraps, oldest slot skipped, count tops out
      for (int i = 0; i < DEPTH; i++) queue_req(REQ_APPEND, 16'hA5A5, 32'h5A5A_5A5A);
      queue_req(REQ_MARK, '0, '0);
      queue_req(REQ_QUERY, 16'hA5A5, 32'h5A5A_5A5A);

      for (int i = 0; i < 4; i++) id_pool[i] = ID_W'($urandom_range(1, 65535));
      turn_pool[0] = '0;
      turn_pool[1] = '1;
      turn_pool[2] = $urandom;

      n_items = 0;
      while (n_items < RANDOM_ITEMS) begin
         kind_sel = $urandom_range(0, 99);
         if (kind_sel < 70) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 99) < 75)
                  queue_req(REQ_APPEND, ($urandom_range(0, 99) < 3) ? NULL_ID : pick_id(),
                            pick_turn());
               else
                  queue_req(REQ_MARK, ID_W'($urandom), $urandom);
            end
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) queue_query();
         end else if (kind_sel < 80) begin
            // same key repeated: counts near the walk limit
            k.id = pick_id();
            k.turn = pick_turn();
            n = $urandom_range(10, DEPTH + 2);
            for (int i = 0; i < n; i++) begin
               queue_req(REQ_APPEND, k.id, k.turn);
               if ($urandom_range(0, 99) < 20) queue_req(REQ_MARK, '0, '0);
            end
            queue_req(REQ_QUERY, k.id, k.turn);
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               queue_req(REQ_W'($urandom_range(0, 3)), ID_W'($urandom), $urandom);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_tvalid || awaited_lookups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words: %0d appends, %0d marks, %0d queries, %0d unused codes",
               acc_count, n_append, n_mark, n_query, n_unused);
      $display("queries: %0d hits, %0d with an effective id; %0d results checked",
               n_hits, n_eff, rsp_count);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== ring_history_log_search_unit.f =====
+incdir+design
design/rhls_pkg.sv
design/ring_history_log_search_unit.sv
design/rhls_checker.sv
sim/ring_history_log_search_unit_tb.sv
